// ===== sv/edfq_pkg.sv =====
// package: shared types and constants for the edf ready queue
package edfq_pkg;
  localparam logic [1:0] FUNC_CREATE = 2'd0;
  localparam logic [1:0] FUNC_DONE   = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;
  localparam int unsigned IdW   = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned DlW   = 33;
  localparam int unsigned NarW  = 5;

  typedef struct packed {
    logic [1:0]       func;
    logic [TimeW-1:0] now_ms;
    logic [IdW-1:0]   new_task_id;
    logic [TimeW-1:0] relative_deadline;
  } req_t;

  typedef struct packed {
    logic             active_valid;
    logic [IdW-1:0]   active_task;
    logic             create_rejected;
    logic [NarW-1:0]  expired_now;
    logic [NarW-1:0]  running_count;
    logic [TimeW-1:0] overdue_count;
    logic [TimeW-1:0] completed_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request
    logic start;    // begin insert scan / clear position
    logic scan;     // compare one entry for insert position
    logic shift_up; // move one entry (up for insert, down for pop)
    logic place;    // write new entry
    logic pop;      // remove head: decrement fill, count expiry
    logic cnt_done;
    logic cnt_miss;
    logic reject;
    logic result;   // latch response
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       empty;
    logic       full;
    logic       scan_end;  // insert position found
    logic       shift_end; // no more entries to move
    logic       head_le;   // head deadline <= now
    logic       head_lt;   // head deadline < now
  } sts_t;
endpackage

// ===== sv/edfq_if.sv =====
// interface: valid/ready channel carrying one payload
interface edfq_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/edfq_ctrl.sv =====
// controller: sequences insert, pop and sweep steps
module edfq_ctrl import edfq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DISP  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_POP   = 7'b0010000,
    S_SWEEP = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   pop_miss_q, pop_miss_d;

  // a new request enters only once the waiting result is taken
  assign in_ready_o  = (state_q == S_IDLE) && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d    = state_q;
    pop_miss_d = pop_miss_q;
    ov_d       = ov_q && !out_ready_i;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && (!ov_q || out_ready_i)) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.func)
          FUNC_CREATE: begin
            if (sts_i.full) begin
              cmd_o.reject = 1'b1;
              state_d      = S_OUT;
            end else begin
              cmd_o.start = 1'b1;
              state_d     = S_SCAN;
            end
          end
          FUNC_DONE: begin
            if (sts_i.empty) state_d = S_OUT;
            else begin
              cmd_o.start = 1'b1;
              cmd_o.cnt_done = 1'b1;
              pop_miss_d = 1'b0;
              state_d = S_POP;
            end
          end
          FUNC_TICK: begin
            if (!sts_i.empty && sts_i.head_le) begin
              cmd_o.start = 1'b1;
              pop_miss_d = 1'b1;
              state_d = S_POP;
            end else state_d = S_OUT;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_end) state_d = S_SHIFT;
        else cmd_o.scan = 1'b1;
      end
      S_SHIFT: begin
        if (sts_i.shift_end) begin
          cmd_o.place = 1'b1;
          state_d     = S_OUT;
        end else cmd_o.shift_up = 1'b1;
      end
      S_POP: begin
        if (sts_i.shift_end) begin
          cmd_o.pop      = 1'b1;
          cmd_o.cnt_miss = pop_miss_q;
          state_d        = S_SWEEP;
        end else cmd_o.shift_up = 1'b1;
      end
      S_SWEEP: begin
        if (!sts_i.empty && sts_i.head_lt) begin
          cmd_o.start = 1'b1;
          pop_miss_d  = 1'b1;
          state_d     = S_POP;
        end else state_d = S_OUT;
      end
      S_OUT: begin
        cmd_o.result = 1'b1;
        ov_d         = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ov_q       <= 1'b0;
      pop_miss_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ov_q       <= ov_d;
      pop_miss_q <= pop_miss_d;
    end
  end
endmodule

// ===== sv/edfq_dp.sv =====
// datapath: sorted task store, walk pointer and counters
module edfq_dp import edfq_pkg::*; #(
  parameter int unsigned Depth = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output rsp_t rsp_o
);
  localparam int unsigned PtrW = $clog2(Depth + 1);
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [IdW-1:0]   ids_q [Depth];
  logic [DlW-1:0]   dls_q [Depth];
  logic [PtrW-1:0]  fill_q, pos_q, wp_q;
  logic [TimeW-1:0] miss_q, done_q;
  req_t             req_q;
  rsp_t             rsp_q;
  logic [DlW-1:0]   new_dl;
  logic [DlW-1:0]   now_x;
  logic [4:0]       exp_q;
  logic             rej_q;

  assign new_dl = {1'b0, req_q.now_ms} + {1'b0, req_q.relative_deadline};
  assign now_x  = {1'b0, req_q.now_ms};

  logic [IdxW-1:0] pos_ix, wp_ix, wpm_ix, wpp_ix;
  assign pos_ix = pos_q[IdxW-1:0];
  assign wp_ix  = wp_q[IdxW-1:0];
  assign wpm_ix = IdxW'(wp_q - PtrW'(1));
  assign wpp_ix = IdxW'(wp_q + PtrW'(1));

  assign sts_o.func      = req_q.func;
  assign sts_o.empty     = (fill_q == '0);
  assign sts_o.full      = (fill_q >= PtrW'(Depth));
  assign sts_o.scan_end  = (pos_q == fill_q) || (dls_q[pos_ix] > new_dl);
  // insert walks down from fill to pos; pop walks up from 0 to fill-1
  assign sts_o.shift_end = (req_q.func == FUNC_CREATE) ? (wp_q == pos_q)
                         : (wp_q + PtrW'(1) >= fill_q);
  assign sts_o.head_le   = (dls_q[0] <= now_x);
  assign sts_o.head_lt   = (dls_q[0] < now_x);
  assign rsp_o           = rsp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.shift_up) begin
      if (req_q.func == FUNC_CREATE) begin
        ids_q[wp_ix] <= ids_q[wpm_ix];
        dls_q[wp_ix] <= dls_q[wpm_ix];
      end else begin
        ids_q[wp_ix] <= ids_q[wpp_ix];
        dls_q[wp_ix] <= dls_q[wpp_ix];
      end
    end
    if (cmd_i.place) begin
      ids_q[pos_ix] <= req_q.new_task_id;
      dls_q[pos_ix] <= new_dl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      wp_q   <= '0;
      miss_q <= '0;
      done_q <= '0;
      exp_q  <= '0;
      rej_q  <= 1'b0;
      rsp_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        exp_q <= '0;
        rej_q <= 1'b0;
      end
      if (cmd_i.start) begin
        pos_q <= '0;
        wp_q  <= '0;
      end
      if (cmd_i.scan) begin
        pos_q <= pos_q + PtrW'(1);
        wp_q  <= fill_q;
      end
      if (cmd_i.shift_up) begin
        wp_q <= (req_q.func == FUNC_CREATE) ? wp_q - PtrW'(1) : wp_q + PtrW'(1);
      end
      // scan exits without asserting scan when pos found at 0: fix wp
      if (!cmd_i.scan && !cmd_i.shift_up && sts_o.scan_end
          && req_q.func == FUNC_CREATE && wp_q != fill_q && wp_q == '0
          && pos_q == '0 && cmd_i.place == 1'b0 && !cmd_i.start) begin
        wp_q <= fill_q;
      end
      if (cmd_i.place) fill_q <= fill_q + PtrW'(1);
      if (cmd_i.pop) begin
        fill_q <= fill_q - PtrW'(1);
        if (cmd_i.cnt_miss && exp_q != 5'd31) exp_q <= exp_q + 5'd1;
      end
      if (cmd_i.cnt_miss && miss_q != '1) miss_q <= miss_q + 1'b1;
      if (cmd_i.cnt_done && done_q != '1) done_q <= done_q + 1'b1;
      if (cmd_i.reject) rej_q <= 1'b1;
      if (cmd_i.result) begin
        rsp_q.active_valid    <= (fill_q != '0);
        rsp_q.active_task     <= (fill_q != '0) ? ids_q[0] : '0;
        rsp_q.create_rejected <= rej_q;
        rsp_q.expired_now     <= exp_q;
        rsp_q.running_count   <= (fill_q > PtrW'(31)) ? 5'd31 : 5'(fill_q);
        rsp_q.overdue_count   <= miss_q;
        rsp_q.completed_count <= done_q;
      end
    end
  end
endmodule

// ===== sv/edf_ready_queue_unit.sv =====
// top level: edf ready queue, controller plus datapath
// create scans to the insert position, shifts later entries up, then places; done/tick pop the head and sweep
// throughput: one request at a time; the insert walk and pop shifts set the cost
// one entry moves per cycle; a new request enters once the waiting result is taken
// reset: asynchronous active low; counters and fill clear, store contents undefined
module edf_ready_queue_unit import edfq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic clk_i,
  input logic rst_ni,
  edfq_if.sink   req_if,
  edfq_if.source rsp_if
);
  sts_t sts;
  cmd_t cmd;

  edfq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req_if.valid), .in_ready_o(req_if.ready),
    .out_valid_o(rsp_if.valid), .out_ready_i(rsp_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  edfq_dp #(.Depth(QUEUE_DEPTH)) u_dp (
    .clk_i, .rst_ni, .req_i(req_if.data), .cmd_i(cmd),
    .sts_o(sts), .rsp_o(rsp_if.data)
  );
endmodule

// ===== sv/edfq_checker.sv =====
// checker: port-level properties of the edf ready queue
module edfq_checker import edfq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t rsp
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(rsp)) else $error("result dropped");
  a_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (rsp.active_valid == (rsp.running_count != '0))) else $error("active");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !rsp.active_valid |-> rsp.active_task == '0) else $error("task");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("ready");
endmodule

bind edf_ready_queue_unit edfq_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid(req_if.valid), .in_ready(req_if.ready),
  .out_valid(rsp_if.valid), .out_ready(rsp_if.ready), .rsp(rsp_if.data)
);
